### design/cpob_pkg.sv
`timescale 1ns / 1ps
package cpob_pkg;

    localparam int COORD_W      = 32;
    localparam int ANGLE_W      = 16;
    localparam int HALF_W       = COORD_W - 1;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int TRIG_W       = 32;
    localparam int TRIG_FRAC    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int PROD1_W      = DIFF_W + TRIG_W;
    localparam int SUM1_W       = PROD1_W + 1;
    localparam int PROJ_W       = SUM1_W - TRIG_FRAC;
    localparam int PROD2_W      = COORD_W + TRIG_W;
    localparam int SUM2_W       = PROD2_W + 1;
    localparam int OFFS_W       = SUM2_W - TRIG_FRAC;
    localparam int WIDE_W       = OFFS_W + 1;

    localparam logic signed [TRIG_W-1:0] GAIN_INV  = TRIG_W'(652032874);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE  = TRIG_W'(1073741824);
    localparam logic signed [TRIG_W-1:0] EIGHTH    = TRIG_W'(536870912);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_center_x;
        logic signed [COORD_W-1:0] box_center_y;
        logic signed [COORD_W-1:0] box_center_z;
        logic [ANGLE_W-1:0]        box_angle;
        logic [HALF_W-1:0]         half_size_x;
        logic [HALF_W-1:0]         half_size_y;
        logic [HALF_W-1:0]         half_size_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_box_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_z;
    } t_near_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic [HALF_W-1:0]         hx;
        logic [HALF_W-1:0]         hy;
        logic [HALF_W-1:0]         hz;
        logic [1:0]                quad;
    } t_carry;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [TRIG_W-1:0] z;
    } t_rot;

    function automatic logic signed [TRIG_W-1:0] atan_at(input logic [STEP_W-1:0] idx);
        logic signed [TRIG_W-1:0] v;
        case (idx)
            5'd0:  v = 536870912;
            5'd1:  v = 316933406;
            5'd2:  v = 167458907;
            5'd3:  v = 85004756;
            5'd4:  v = 42667331;
            5'd5:  v = 21354465;
            5'd6:  v = 10679838;
            5'd7:  v = 5340245;
            5'd8:  v = 2670163;
            5'd9:  v = 1335087;
            5'd10: v = 667544;
            5'd11: v = 333772;
            5'd12: v = 166886;
            5'd13: v = 83443;
            5'd14: v = 41722;
            5'd15: v = 20861;
            5'd16: v = 10430;
            5'd17: v = 5215;
            5'd18: v = 2608;
            5'd19: v = 1304;
            5'd20: v = 652;
            5'd21: v = 326;
            5'd22: v = 163;
            5'd23: v = 81;
            5'd24: v = 41;
            5'd25: v = 20;
            5'd26: v = 10;
            5'd27: v = 5;
            5'd28: v = 3;
            5'd29: v = 1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) return hi[COORD_W-1:0];
        if (v < lo) return lo[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

endpackage

### design/cpob_if.sv
`timescale 1ns / 1ps
interface cpob_in_if;
    import cpob_pkg::*;
    logic      valid;
    logic      ready;
    t_box_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpob_out_if;
    import cpob_pkg::*;
    logic       valid;
    logic       ready;
    t_near_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/cpob_cordic_cell.sv
`timescale 1ns / 1ps
module cpob_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [cpob_pkg::STEP_W-1:0]   i_step,
    input  logic                          i_valid,
    input  cpob_pkg::t_rot                i_rot,
    input  cpob_pkg::t_carry              i_carry,
    output logic                          o_valid,
    output cpob_pkg::t_rot                o_rot,
    output cpob_pkg::t_carry              o_carry
);
    import cpob_pkg::*;

    logic            r_valid;
    t_rot            r_rot;
    t_carry          r_carry;
    t_rot            n_rot;
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] ang;

    always_comb begin
        sx  = i_rot.x >>> i_step;
        sy  = i_rot.y >>> i_step;
        ang = atan_at(i_step);
        if (!i_rot.z[TRIG_W-1]) begin
            n_rot.x = i_rot.x - sy;
            n_rot.y = i_rot.y + sx;
            n_rot.z = i_rot.z - ang;
        end else begin
            n_rot.x = i_rot.x + sy;
            n_rot.y = i_rot.y - sx;
            n_rot.z = i_rot.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot   <= n_rot;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_carry = r_carry;

endmodule

### design/cpob_rebuild.sv
`timescale 1ns / 1ps
module cpob_rebuild (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  cpob_pkg::t_rot       i_rot,
    input  cpob_pkg::t_carry     i_carry,
    output logic                 o_valid,
    output cpob_pkg::t_near_item o_near
);
    import cpob_pkg::*;

    localparam logic signed [SUM1_W-1:0] HALF1 = SUM1_W'(536870912);
    localparam logic signed [SUM2_W-1:0] HALF2 = SUM2_W'(536870912);

    logic [6:0] r_valid;

    // stage 1: trig clamp and quadrant
    logic signed [TRIG_W-1:0] n1_c, n1_s, cx_cl, cy_cl;
    logic signed [TRIG_W-1:0] r1_c, r1_s;
    t_carry r1_carry;
    // stage 2: projection products
    logic signed [PROD1_W-1:0] r2_xc, r2_ys, r2_xs, r2_yc;
    logic signed [TRIG_W-1:0]  r2_c, r2_s;
    t_carry r2_carry;
    // stage 3: projection rounding
    logic signed [SUM1_W-1:0]  s3_u, s3_v;
    logic signed [PROJ_W-1:0]  r3_u, r3_v;
    logic signed [TRIG_W-1:0]  r3_c, r3_s;
    t_carry r3_carry;
    // stage 4: clamp to half-extent
    logic signed [PROJ_W-1:0]  hxs, hys;
    logic signed [DIFF_W-1:0]  hzs;
    logic signed [COORD_W-1:0] n4_u, n4_v, n4_w;
    logic signed [COORD_W-1:0] r4_u, r4_v, r4_w;
    logic signed [TRIG_W-1:0]  r4_c, r4_s;
    t_carry r4_carry;
    // stage 5: rebuild products
    logic signed [PROD2_W-1:0] r5_uc, r5_vs, r5_us, r5_vc;
    logic signed [COORD_W-1:0] r5_w;
    t_carry r5_carry;
    // stage 6: rebuild rounding
    logic signed [SUM2_W-1:0]  s6_x, s6_y;
    logic signed [OFFS_W-1:0]  r6_x, r6_y;
    logic signed [COORD_W-1:0] r6_w;
    t_carry r6_carry;
    // stage 7: add center, saturate
    t_near_item r7_near;

    always_comb begin
        cx_cl = i_rot.x;
        cy_cl = i_rot.y;
        if (cx_cl > TRIG_ONE) cx_cl = TRIG_ONE;
        if (cx_cl < -TRIG_ONE) cx_cl = -TRIG_ONE;
        if (cy_cl > TRIG_ONE) cy_cl = TRIG_ONE;
        if (cy_cl < -TRIG_ONE) cy_cl = -TRIG_ONE;
        case (i_carry.quad)
            QUAD_0: begin n1_c = cx_cl;  n1_s = cy_cl;  end
            QUAD_1: begin n1_c = -cy_cl; n1_s = cx_cl;  end
            QUAD_2: begin n1_c = -cx_cl; n1_s = -cy_cl; end
            default: begin n1_c = cy_cl; n1_s = -cx_cl; end
        endcase
    end

    always_comb begin
        s3_u = SUM1_W'(r2_xc) + SUM1_W'(r2_ys) + HALF1;
        s3_v = SUM1_W'(r2_yc) - SUM1_W'(r2_xs) + HALF1;
    end

    always_comb begin
        hxs = $signed(PROJ_W'({1'b0, r3_carry.hx}));
        hys = $signed(PROJ_W'({1'b0, r3_carry.hy}));
        hzs = $signed(DIFF_W'({1'b0, r3_carry.hz}));
        n4_u = r3_u[COORD_W-1:0];
        if (r3_u > hxs) n4_u = hxs[COORD_W-1:0];
        if (r3_u < -hxs) n4_u = -hxs[COORD_W-1:0];
        n4_v = r3_v[COORD_W-1:0];
        if (r3_v > hys) n4_v = hys[COORD_W-1:0];
        if (r3_v < -hys) n4_v = -hys[COORD_W-1:0];
        n4_w = r3_carry.dz[COORD_W-1:0];
        if (r3_carry.dz > hzs) n4_w = hzs[COORD_W-1:0];
        if (r3_carry.dz < -hzs) n4_w = -hzs[COORD_W-1:0];
    end

    always_comb begin
        s6_x = SUM2_W'(r5_uc) - SUM2_W'(r5_vs) + HALF2;
        s6_y = SUM2_W'(r5_us) + SUM2_W'(r5_vc) + HALF2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c     <= n1_c;
            r1_s     <= n1_s;
            r1_carry <= i_carry;

            r2_xc    <= r1_carry.dx * r1_c;
            r2_ys    <= r1_carry.dy * r1_s;
            r2_xs    <= r1_carry.dx * r1_s;
            r2_yc    <= r1_carry.dy * r1_c;
            r2_c     <= r1_c;
            r2_s     <= r1_s;
            r2_carry <= r1_carry;

            r3_u     <= s3_u[SUM1_W-1:TRIG_FRAC];
            r3_v     <= s3_v[SUM1_W-1:TRIG_FRAC];
            r3_c     <= r2_c;
            r3_s     <= r2_s;
            r3_carry <= r2_carry;

            r4_u     <= n4_u;
            r4_v     <= n4_v;
            r4_w     <= n4_w;
            r4_c     <= r3_c;
            r4_s     <= r3_s;
            r4_carry <= r3_carry;

            r5_uc    <= r4_u * r4_c;
            r5_vs    <= r4_v * r4_s;
            r5_us    <= r4_u * r4_s;
            r5_vc    <= r4_v * r4_c;
            r5_w     <= r4_w;
            r5_carry <= r4_carry;

            r6_x     <= s6_x[SUM2_W-1:TRIG_FRAC];
            r6_y     <= s6_y[SUM2_W-1:TRIG_FRAC];
            r6_w     <= r5_w;
            r6_carry <= r5_carry;

            r7_near.near_x <= sat_coord(WIDE_W'(r6_carry.cx) + WIDE_W'(r6_x));
            r7_near.near_y <= sat_coord(WIDE_W'(r6_carry.cy) + WIDE_W'(r6_y));
            r7_near.near_z <= sat_coord(WIDE_W'(r6_carry.cz) + WIDE_W'(r6_w));
        end
    end

    assign o_valid = r_valid[6];
    assign o_near  = r7_near;

endmodule

### design/closest_point_on_oriented_box_core.sv
`timescale 1ns / 1ps
// Register stages from input accept to result valid: 1 input stage, 30 CORDIC cells,
// 7 projection/rebuild stages, 1 output register.
// Throughput: one item per cycle; the whole pipeline advances while the skid slot is empty.
// A stalled output holds one result plus one in the skid slot before input ready drops.
// Reset (synchronous, active low) clears all valid flags; payload registers are not reset.
module closest_point_on_oriented_box_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpob_in_if.sink           i_box,
    cpob_out_if.source        o_near
);
    import cpob_pkg::*;

    logic en;
    logic r_in_valid;
    t_rot r_in_rot;
    t_carry r_in_carry;
    t_rot n_in_rot;
    t_carry n_in_carry;
    logic [TRIG_W-1:0] a_turn, t_turn;

    logic   c_valid [CORDIC_STEPS+1];
    t_rot   c_rot   [CORDIC_STEPS+1];
    t_carry c_carry [CORDIC_STEPS+1];

    logic       p_valid;
    t_near_item p_near;

    logic       r_out_valid, r_skid_valid;
    t_near_item r_out, r_skid;
    logic       take;

    assign en          = !r_skid_valid;
    assign i_box.ready = en;

    always_comb begin
        a_turn = {i_box.data.box_angle, {(TRIG_W-ANGLE_W){1'b0}}};
        t_turn = a_turn + EIGHTH;
        n_in_rot.x = GAIN_INV;
        n_in_rot.y = '0;
        n_in_rot.z = $signed({2'b00, t_turn[TRIG_W-3:0]}) - EIGHTH;
        n_in_carry.quad = t_turn[TRIG_W-1:TRIG_W-2];
        n_in_carry.cx = i_box.data.box_center_x;
        n_in_carry.cy = i_box.data.box_center_y;
        n_in_carry.cz = i_box.data.box_center_z;
        n_in_carry.dx = DIFF_W'(i_box.data.point_x) - DIFF_W'(i_box.data.box_center_x);
        n_in_carry.dy = DIFF_W'(i_box.data.point_y) - DIFF_W'(i_box.data.box_center_y);
        n_in_carry.dz = DIFF_W'(i_box.data.point_z) - DIFF_W'(i_box.data.box_center_z);
        n_in_carry.hx = i_box.data.half_size_x;
        n_in_carry.hy = i_box.data.half_size_y;
        n_in_carry.hz = i_box.data.half_size_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_rot   <= n_in_rot;
            r_in_carry <= n_in_carry;
        end
    end

    assign c_valid[0] = r_in_valid;
    assign c_rot[0]   = r_in_rot;
    assign c_carry[0] = r_in_carry;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        cpob_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (STEP_W'(k)),
            .i_valid (c_valid[k]),
            .i_rot   (c_rot[k]),
            .i_carry (c_carry[k]),
            .o_valid (c_valid[k+1]),
            .o_rot   (c_rot[k+1]),
            .o_carry (c_carry[k+1])
        );
    end

    cpob_rebuild u_rebuild (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid[CORDIC_STEPS]),
        .i_rot   (c_rot[CORDIC_STEPS]),
        .i_carry (c_carry[CORDIC_STEPS]),
        .o_valid (p_valid),
        .o_near  (p_near)
    );

    assign take = r_out_valid && o_near.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (p_valid) begin
            if (!r_out_valid || take) begin
                r_out       <= p_near;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= p_near;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_near.valid = r_out_valid;
    assign o_near.data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full while output empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !o_near.ready |=> r_skid_valid)
        else $error("skid slot lost an item");

    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_box.ready) |-> $past(take))
        else $error("input reopened without an output transfer");

endmodule
